### src/gcd_pkg.sv
// Shared types, constants and table functions for the great-circle distance unit.
package gcd_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int CORDIC_STAGES   = 24;

    localparam int COORD_W  = 25;
    localparam int MAG_W    = 26;
    localparam int FACT_W   = 33;
    localparam int FACT_LO  = 16;
    localparam int RAD_W    = 38;
    localparam int ANG_W    = 33;
    localparam int PI_W     = 34;
    localparam int CW       = 34;
    localparam int ZW       = 36;
    localparam int UNIT_W   = 31;
    localparam int ROOT_W   = 31;
    localparam int SQ_IN_W  = 61;
    localparam int RADIUS_W = 24;
    localparam int DIST_W   = 30;

    localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_Q32_FULL = (PI_Q60 + (64'd1 << 27)) >> 28;
    localparam logic [PI_W-1:0]  PI_Q32      = PI_W'(PI_Q32_FULL);
    localparam logic [ANG_W-1:0] HALF_PI_Q32 = ANG_W'(PI_Q32_FULL / 2);
    localparam logic [63:0] DEG2RAD_FULL = ((PI_Q60 >> 22) + 64'd90) / 64'd180;
    localparam logic [FACT_W-1:0] DEG2RAD_Q38 = FACT_W'(DEG2RAD_FULL);
    localparam logic [CW-1:0] GAIN_Q30 = CW'(652032874);
    localparam logic [UNIT_W-1:0] ONE_Q30 = UNIT_W'(1) << 30;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(6372797);
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam int LAT_LIM = 90 << COORD_FRAC_BITS;
    localparam int LON_LIM = 180 << COORD_FRAC_BITS;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [DIST_W-1:0]         t_dist;
    typedef logic [RADIUS_W-1:0]       t_radius;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_FIRST  = 2'd1,
        ST_BAD_SECOND = 2'd2
    } t_status;

    // Arctangent of 2^-i in radians with 32 fraction bits, built from the series.
    function automatic logic [63:0] atan_q32(input int i);
        logic [63:0] acc;
        logic [63:0] term;
        int k;
        int e;
        acc = '0;
        if (i == 0) begin
            return (PI_Q60 + (64'd1 << 29)) >> 30;
        end
        for (k = 0; k < 63; k++) begin
            e = i * (2 * k + 1);
            if (e <= 62) begin
                term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
                if (k % 2 == 1) acc = acc - term;
                else            acc = acc + term;
            end
        end
        return (acc + (64'd1 << 29)) >> 30;
    endfunction

    // Clamps a CORDIC coordinate to the range zero to one.
    function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [CW-1:0] v);
        if (v < 0) begin
            return '0;
        end else if (v > $signed(CW'(ONE_Q30))) begin
            return ONE_Q30;
        end
        return UNIT_W'(v);
    endfunction

endpackage

### src/gcd_in_if.sv
// Input channel carrying one pair of points per word.
interface gcd_in_if;
    logic            valid;
    logic            ready;
    gcd_pkg::t_coord first_lat;
    gcd_pkg::t_coord first_lon;
    gcd_pkg::t_coord second_lat;
    gcd_pkg::t_coord second_lon;

    modport source(output valid, first_lat, first_lon, second_lat, second_lon, input ready);
    modport sink(input valid, first_lat, first_lon, second_lat, second_lon, output ready);
endinterface

### src/gcd_out_if.sv
// Output channel carrying one distance and status per word.
interface gcd_out_if;
    logic             valid;
    logic             ready;
    gcd_pkg::t_dist   distance;
    gcd_pkg::t_status location_status;

    modport source(output valid, distance, location_status, input ready);
    modport sink(input valid, distance, location_status, output ready);
endinterface

### src/gcd_cordic.sv
// Pipelined CORDIC, one micro-rotation per register stage, rotation or vectoring mode.
module gcd_cordic (
    input  logic                            i_clk,
    input  logic                            i_ce,
    input  logic                            i_vec,
    input  logic signed [gcd_pkg::CW-1:0]   i_x,
    input  logic signed [gcd_pkg::CW-1:0]   i_y,
    input  logic signed [gcd_pkg::ZW-1:0]   i_z,
    output logic signed [gcd_pkg::CW-1:0]   o_x,
    output logic signed [gcd_pkg::CW-1:0]   o_y,
    output logic signed [gcd_pkg::ZW-1:0]   o_z
);
    import gcd_pkg::*;

    logic signed [CW-1:0] r_x [CORDIC_STAGES];
    logic signed [CW-1:0] r_y [CORDIC_STAGES];
    logic signed [ZW-1:0] r_z [CORDIC_STAGES];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        localparam logic signed [ZW-1:0] ATAN = ZW'(atan_q32(i));
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 plus;
        logic signed [CW-1:0] n_x;
        logic signed [CW-1:0] n_y;
        logic signed [ZW-1:0] n_z;

        if (i == 0) begin : g_first
            assign x = i_x;
            assign y = i_y;
            assign z = i_z;
        end else begin : g_next
            assign x = r_x[i-1];
            assign y = r_y[i-1];
            assign z = r_z[i-1];
        end

        // Rotation drives the angle toward zero; vectoring drives y toward zero.
        assign plus = i_vec ? (y < 0) : (z >= 0);

        always_comb begin
            if (plus) begin
                n_x = x - (y >>> i);
                n_y = y + (x >>> i);
                n_z = z - ATAN;
            end else begin
                n_x = x + (y >>> i);
                n_y = y - (x >>> i);
                n_z = z + ATAN;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_x[i] <= n_x;
                r_y[i] <= n_y;
                r_z[i] <= n_z;
            end
        end
    end

    assign o_x = r_x[CORDIC_STAGES-1];
    assign o_y = r_y[CORDIC_STAGES-1];
    assign o_z = r_z[CORDIC_STAGES-1];
endmodule

### src/gcd_sqrt.sv
// Pipelined floor square root, one result bit per register stage.
module gcd_sqrt (
    input  logic                          i_clk,
    input  logic                          i_ce,
    input  logic [gcd_pkg::SQ_IN_W-1:0]   i_n,
    output logic [gcd_pkg::ROOT_W-1:0]    o_root
);
    import gcd_pkg::*;

    localparam int REM_W  = SQ_IN_W + 1;
    localparam int TEST_W = 2 * ROOT_W + 1;

    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        localparam int B = ROOT_W - 1 - j;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [TEST_W-1:0] test;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        if (j == 0) begin : g_first
            assign rem  = REM_W'(i_n);
            assign root = '0;
        end else begin : g_next
            assign rem  = r_rem[j-1];
            assign root = r_root[j-1];
        end

        // (root + 2^B)^2 - root^2 is the amount the remainder must cover.
        assign test = (TEST_W'(root) << (B + 1)) + (TEST_W'(1) << (2 * B));

        always_comb begin
            if (TEST_W'(rem) >= test) begin
                n_rem  = REM_W'(TEST_W'(rem) - test);
                n_root = root | (ROOT_W'(1) << B);
            end else begin
                n_rem  = rem;
                n_root = root;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[j]  <= n_rem;
                r_root[j] <= n_root;
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];
endmodule

### src/great_circle_distance_unit.sv
// Top level of the haversine great-circle distance pipeline.
//
// Usage: each word on i_in carries two points, latitude and longitude in signed
// degrees with 16 fraction bits. Each word on o_out carries the distance in
// metres with 4 fraction bits and a status: OK, first point out of range, or
// second point out of range. An invalid point gives a distance of zero.
// The sphere radius in whole metres is written through i_cfg_we/i_cfg_data;
// the user must write it only while the pipeline is empty, as the block itself
// does not enforce this; reset loads the mean Earth radius. The pipeline
// accepts one word every cycle while its last stage is empty or taken, and runs
// through the two CORDIC chains and the bit-per-stage square root, each stage
// one register. All stages share one enable: when the output word is held and
// not taken, the whole pipeline freezes, and i_in.ready drops, so no word is
// lost or repeated. Synchronous reset clears all valid bits and empties the
// pipeline.
module great_circle_distance_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    gcd_in_if.sink                   i_in,
    gcd_out_if.source                o_out,
    input  logic                     i_cfg_we,
    input  logic [gcd_pkg::RADIUS_W-1:0] i_cfg_data
);
    import gcd_pkg::*;

    localparam int PIPE_LAT = 12 + 2 * CORDIC_STAGES + ROOT_W;
    localparam int SH_DIFF  = COORD_FRAC_BITS + 7;
    localparam int SH_LAT   = COORD_FRAC_BITS + 6;
    localparam int FULL_W   = MAG_W + FACT_W + 1;
    localparam int HI_W     = FACT_W - FACT_LO;
    localparam int ANG_LO   = 16;
    localparam int PROD_W   = RADIUS_W + ANG_W + 2;

    localparam logic [HI_W-1:0]    DEG_HI = DEG2RAD_Q38[FACT_W-1:FACT_LO];
    localparam logic [FACT_LO-1:0] DEG_LO = DEG2RAD_Q38[FACT_LO-1:0];

    logic ce;

    // Radius register.
    t_radius r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_data;
        end
    end

    // Valid bits travel alongside the data through every stage, the status from stage 1 on.
    logic [PIPE_LAT-1:0] r_vld;
    t_status             r_stat [1:PIPE_LAT-1];

    assign ce          = !r_vld[PIPE_LAT-1] || o_out.ready;
    assign i_in.ready  = ce;
    assign o_out.valid = r_vld[PIPE_LAT-1];
    assign o_out.location_status = r_stat[PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_in.valid};
        end
    end

    // Stage 0: capture the coordinates.
    t_coord r0_lat_a, r0_lon_a, r0_lat_b, r0_lon_b;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r0_lat_a <= i_in.first_lat;
            r0_lon_a <= i_in.first_lon;
            r0_lat_b <= i_in.second_lat;
            r0_lon_b <= i_in.second_lon;
        end
    end

    // Stage 1: range checks, differences and magnitudes.
    // Lanes: 0 latitude difference, 1 longitude difference, 2/3 the two latitudes.
    logic       ok_a, ok_b;
    t_status    n_stat1;
    logic signed [MAG_W-1:0] d_lat, d_lon;
    logic [MAG_W-1:0] n_m [4];
    logic [MAG_W-1:0] r1_m [4];

    assign ok_a = (int'(r0_lat_a) >= -LAT_LIM) && (int'(r0_lat_a) <= LAT_LIM) &&
                  (int'(r0_lon_a) >= -LON_LIM) && (int'(r0_lon_a) <= LON_LIM);
    assign ok_b = (int'(r0_lat_b) >= -LAT_LIM) && (int'(r0_lat_b) <= LAT_LIM) &&
                  (int'(r0_lon_b) >= -LON_LIM) && (int'(r0_lon_b) <= LON_LIM);

    assign d_lat = MAG_W'(r0_lat_b) - MAG_W'(r0_lat_a);
    assign d_lon = MAG_W'(r0_lon_b) - MAG_W'(r0_lon_a);

    always_comb begin
        if (!ok_a)      n_stat1 = ST_BAD_FIRST;
        else if (!ok_b) n_stat1 = ST_BAD_SECOND;
        else            n_stat1 = ST_OK;
        n_m[0] = d_lat[MAG_W-1] ? MAG_W'(-d_lat) : MAG_W'(d_lat);
        n_m[1] = d_lon[MAG_W-1] ? MAG_W'(-d_lon) : MAG_W'(d_lon);
        n_m[2] = r0_lat_a[COORD_W-1] ? MAG_W'(-MAG_W'(r0_lat_a)) : MAG_W'(r0_lat_a);
        n_m[3] = r0_lat_b[COORD_W-1] ? MAG_W'(-MAG_W'(r0_lat_b)) : MAG_W'(r0_lat_b);
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_m <= n_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_stat[1] <= n_stat1;
            for (int k = 2; k < PIPE_LAT; k++) begin
                r_stat[k] <= r_stat[k-1];
            end
        end
    end

    // Stage 2: degrees-to-radians factor as two partial products.
    logic [MAG_W+HI_W-1:0]    r2_hi [4];
    logic [MAG_W+FACT_LO-1:0] r2_lo [4];

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int k = 0; k < 4; k++) begin
                r2_hi[k] <= (MAG_W+HI_W)'(r1_m[k]) * (MAG_W+HI_W)'(DEG_HI);
                r2_lo[k] <= (MAG_W+FACT_LO)'(r1_m[k]) * (MAG_W+FACT_LO)'(DEG_LO);
            end
        end
    end

    // Stage 3: combine, round half up and scale to radians with 32 fraction bits.
    // Half differences take one more shift than the plain latitudes.
    logic [FULL_W-1:0] full [4];
    logic [RAD_W-1:0]  r3_rad [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            full[k] = (FULL_W'(r2_hi[k]) << FACT_LO) + FULL_W'(r2_lo[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r3_rad[0] <= RAD_W'((full[0] + (FULL_W'(1) << (SH_DIFF - 1))) >> SH_DIFF);
            r3_rad[1] <= RAD_W'((full[1] + (FULL_W'(1) << (SH_DIFF - 1))) >> SH_DIFF);
            r3_rad[2] <= RAD_W'((full[2] + (FULL_W'(1) << (SH_LAT - 1))) >> SH_LAT);
            r3_rad[3] <= RAD_W'((full[3] + (FULL_W'(1) << (SH_LAT - 1))) >> SH_LAT);
        end
    end

    // Stage 4: fold half differences into the first quadrant, clamp latitudes.
    logic [PI_W-1:0]  t_diff [2];
    logic [ANG_W-1:0] r4_ang [4];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            t_diff[k] = (r3_rad[k] > RAD_W'(PI_Q32)) ? PI_Q32 : PI_W'(r3_rad[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int k = 0; k < 2; k++) begin
                if (t_diff[k] > PI_W'(HALF_PI_Q32)) begin
                    r4_ang[k] <= ANG_W'(PI_Q32 - t_diff[k]);
                end else begin
                    r4_ang[k] <= ANG_W'(t_diff[k]);
                end
            end
            for (int k = 2; k < 4; k++) begin
                if (r3_rad[k] > RAD_W'(HALF_PI_Q32)) begin
                    r4_ang[k] <= HALF_PI_Q32;
                end else begin
                    r4_ang[k] <= ANG_W'(r3_rad[k]);
                end
            end
        end
    end

    // Four rotation CORDICs: sines of the half differences, cosines of the latitudes.
    logic signed [CW-1:0] rot_x [4];
    logic signed [CW-1:0] rot_y [4];

    for (genvar k = 0; k < 4; k++) begin : g_rot
        gcd_cordic u_rot (
            .i_clk (i_clk),
            .i_ce  (ce),
            .i_vec (1'b0),
            .i_x   (GAIN_Q30),
            .i_y   ('0),
            .i_z   (ZW'(r4_ang[k])),
            .o_x   (rot_x[k]),
            .o_y   (rot_y[k]),
            .o_z   ()
        );
    end

    // Stage 5: clamp to zero..one.
    logic [UNIT_W-1:0] r5_s_lat, r5_s_lon, r5_c_a, r5_c_b;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r5_s_lat <= clamp_unit(rot_y[0]);
            r5_s_lon <= clamp_unit(rot_y[1]);
            r5_c_a   <= clamp_unit(rot_x[2]);
            r5_c_b   <= clamp_unit(rot_x[3]);
        end
    end

    // Stage 6: squares of the sines and product of the cosines, truncated.
    localparam int PR_W = 2 * UNIT_W;
    logic [UNIT_W-1:0] r6_sq_lat, r6_sq_lon, r6_cc;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r6_sq_lat <= UNIT_W'((PR_W'(r5_s_lat) * PR_W'(r5_s_lat)) >> 30);
            r6_sq_lon <= UNIT_W'((PR_W'(r5_s_lon) * PR_W'(r5_s_lon)) >> 30);
            r6_cc     <= UNIT_W'((PR_W'(r5_c_a) * PR_W'(r5_c_b)) >> 30);
        end
    end

    // Stage 7: cosine product times the longitude term.
    logic [UNIT_W-1:0] r7_sq_lat, r7_t;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r7_sq_lat <= r6_sq_lat;
            r7_t      <= UNIT_W'((PR_W'(r6_cc) * PR_W'(r6_sq_lon)) >> 30);
        end
    end

    // Stage 8: haversine term, clamped to one.
    logic [UNIT_W:0]   a_sum;
    logic [UNIT_W-1:0] r8_a;

    assign a_sum = (UNIT_W+1)'(r7_sq_lat) + (UNIT_W+1)'(r7_t);

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r8_a <= (a_sum > (UNIT_W+1)'(ONE_Q30)) ? ONE_Q30 : UNIT_W'(a_sum);
        end
    end

    // Square roots of a and 1-a with 30 fraction bits.
    logic [ROOT_W-1:0] root_u, root_v;

    gcd_sqrt u_sqrt_u (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_n    ({r8_a, 30'd0}),
        .o_root (root_u)
    );

    gcd_sqrt u_sqrt_v (
        .i_clk  (i_clk),
        .i_ce   (ce),
        .i_n    ({UNIT_W'(ONE_Q30 - r8_a), 30'd0}),
        .o_root (root_v)
    );

    // Vectoring CORDIC gives the central half angle atan2(u, v).
    logic signed [ZW-1:0] vec_z;

    gcd_cordic u_vec (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_vec (1'b1),
        .i_x   (CW'(root_v)),
        .i_y   (CW'(root_u)),
        .i_z   ('0),
        .o_x   (),
        .o_y   (),
        .o_z   (vec_z)
    );

    // Stage 9: clamp the angle to zero..pi/2.
    logic [ANG_W-1:0] r9_ang;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            if (vec_z < 0) begin
                r9_ang <= '0;
            end else if (vec_z > $signed(ZW'(HALF_PI_Q32))) begin
                r9_ang <= HALF_PI_Q32;
            end else begin
                r9_ang <= ANG_W'(vec_z);
            end
        end
    end

    // Stage 10: radius times angle as two partial products.
    logic [RADIUS_W+ANG_W-ANG_LO-1:0] r10_hi;
    logic [RADIUS_W+ANG_LO-1:0]       r10_lo;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r10_hi <= (RADIUS_W+ANG_W-ANG_LO)'(r_radius) *
                      (RADIUS_W+ANG_W-ANG_LO)'(r9_ang[ANG_W-1:ANG_LO]);
            r10_lo <= (RADIUS_W+ANG_LO)'(r_radius) * (RADIUS_W+ANG_LO)'(r9_ang[ANG_LO-1:0]);
        end
    end

    // Stage 11: round, scale to metres with 4 fraction bits, saturate, and
    // force zero for an out-of-range point.
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-28:0]  dist_wide;
    t_dist               r11_dist;

    assign prod      = (PROD_W'(r10_hi) << ANG_LO) + PROD_W'(r10_lo) + (PROD_W'(1) << 26);
    assign dist_wide = (PROD_W-27)'(prod >> 27);

    always_ff @(posedge i_clk) begin
        if (ce) begin
            if (r_stat[PIPE_LAT-2] != ST_OK) begin
                r11_dist <= '0;
            end else if (dist_wide > (PROD_W-27)'(DIST_MAX)) begin
                r11_dist <= DIST_MAX;
            end else begin
                r11_dist <= DIST_W'(dist_wide);
            end
        end
    end

    assign o_out.distance = r11_dist;

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.location_status != ST_OK) |-> (o_out.distance == '0))
        else $error("out-of-range point produced a nonzero distance");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.location_status == ST_OK) ||
                        (o_out.location_status == ST_BAD_FIRST) ||
                        (o_out.location_status == ST_BAD_SECOND))
        else $error("undefined status code on output");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid directly after reset");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !ce |=> $stable(r_vld))
        else $error("valid chain moved while the pipeline was frozen");
`endif
endmodule
